@@ sv/slx_pkg.sv @@
// Shared types and constants of the shell line lexer and validator.
// Used by the lexer front end, the event queue and the grammar back end.
package slx_pkg;

  localparam int StartW = 12;
  localparam int LenW = 13;
  localparam int CountW = 13;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW = $clog2(FifoDepth);
  localparam int FifoCntW = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChVtab = 8'h0B;
  localparam logic [7:0] ChFeed = 8'h0C;
  localparam logic [7:0] ChReturn = 8'h0D;
  localparam logic [7:0] ChPipe = 8'h7C;
  localparam logic [7:0] ChAmp = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChLess = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;

  typedef enum logic [2:0] {
    TK_NAME   = 3'd0,
    TK_PIPE   = 3'd1,
    TK_AMP    = 3'd2,
    TK_SEMI   = 3'd3,
    TK_IN     = 3'd4,
    TK_OUT    = 3'd5,
    TK_APPEND = 3'd6
  } tok_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NAME = 2'd1,
    MODE_GT   = 2'd2
  } lex_mode_e;

  typedef enum logic [2:0] {
    GS_START = 3'd0,
    GS_NAME  = 3'd1,
    GS_REDIR = 3'd2,
    GS_PIPE  = 3'd3,
    GS_SEMI  = 3'd4,
    GS_AMP   = 3'd5,
    GS_ERR   = 3'd6
  } gram_state_e;

  // One record: a token, or the end-of-line verdict.
  typedef struct packed {
    logic              is_verdict;
    tok_kind_e         tk;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic              ovf;
  } slx_rec_t;

  // All records caused by one byte, one or two of them.
  typedef struct packed {
    logic     two;
    slx_rec_t r0;
    slx_rec_t r1;
  } slx_entry_t;

  function automatic slx_rec_t mk_tok(tok_kind_e tk, logic [StartW-1:0] start,
                                      logic [LenW-1:0] len);
    slx_rec_t r;
    r.is_verdict = 1'b0;
    r.tk = tk;
    r.start = start;
    r.len = len;
    r.ovf = 1'b0;
    return r;
  endfunction

  function automatic slx_rec_t mk_verdict(logic ovf);
    slx_rec_t r;
    r.is_verdict = 1'b1;
    r.tk = TK_NAME;
    r.start = '0;
    r.len = '0;
    r.ovf = ovf;
    return r;
  endfunction

endpackage

@@ sv/slx_front.sv @@
// Lexer front end: takes one byte per transaction and turns it into token events.
// Depends on slx_pkg; pushes one queue entry per byte that causes any record.
module slx_front import slx_pkg::*; #(
  parameter int MAX_LINE = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output slx_entry_t q_data_o
);

  localparam int PosW = $clog2(MAX_LINE + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LINE);

  lex_mode_e       mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] start_q, start_d;
  logic            ovf_q, ovf_d;

  logic            accept;
  logic            a_v, b_v, done;
  slx_rec_t        rec_a, rec_b;
  logic [PosW-1:0] name_len;
  logic            is_space, is_op;

  assign in_stall_o = q_full_i;
  assign accept = in_valid_i && !q_full_i;
  assign name_len = pos_q - start_q;

  always_comb begin
    is_space = (ch_i == ChSpace) || (ch_i == ChTab) || (ch_i == ChNewline) ||
               (ch_i == ChVtab) || (ch_i == ChFeed) || (ch_i == ChReturn);
    is_op = (ch_i == ChPipe) || (ch_i == ChAmp) || (ch_i == ChSemi) ||
            (ch_i == ChLess) || (ch_i == ChGreater);
  end

  always_comb begin
    mode_d = mode_q;
    pos_d = pos_q;
    start_d = start_q;
    ovf_d = ovf_q;
    a_v = 1'b0;
    b_v = 1'b0;
    done = 1'b0;
    rec_a = mk_tok(TK_NAME, StartW'(start_q), LenW'(name_len));
    rec_b = mk_verdict(ovf_q);
    if (accept) begin
      if (ch_i == ChNul) begin
        unique case (mode_q)
          MODE_NAME: begin
            a_v = 1'b1;
          end
          MODE_GT: begin
            a_v = 1'b1;
            rec_a = mk_tok(TK_OUT, StartW'(start_q), LenW'(1));
          end
          default: a_v = 1'b0;
        endcase
        b_v = 1'b1;
        mode_d = MODE_IDLE;
        pos_d = '0;
        start_d = '0;
        ovf_d = 1'b0;
      end else if (pos_q >= MaxPos) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + PosW'(1);
        unique case (mode_q)
          MODE_GT: begin
            mode_d = MODE_IDLE;
            a_v = 1'b1;
            if (ch_i == ChGreater) begin
              rec_a = mk_tok(TK_APPEND, StartW'(start_q), LenW'(2));
              done = 1'b1;
            end else begin
              rec_a = mk_tok(TK_OUT, StartW'(start_q), LenW'(1));
            end
          end
          MODE_NAME: begin
            if (is_space || is_op) begin
              mode_d = MODE_IDLE;
              a_v = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          default: a_v = 1'b0;
        endcase
        if (!done && !is_space) begin
          case (ch_i)
            ChPipe: begin
              b_v = 1'b1;
              rec_b = mk_tok(TK_PIPE, StartW'(pos_q), LenW'(1));
            end
            ChAmp: begin
              b_v = 1'b1;
              rec_b = mk_tok(TK_AMP, StartW'(pos_q), LenW'(1));
            end
            ChSemi: begin
              b_v = 1'b1;
              rec_b = mk_tok(TK_SEMI, StartW'(pos_q), LenW'(1));
            end
            ChLess: begin
              b_v = 1'b1;
              rec_b = mk_tok(TK_IN, StartW'(pos_q), LenW'(1));
            end
            ChGreater: begin
              mode_d = MODE_GT;
              start_d = pos_q;
            end
            default: begin
              mode_d = MODE_NAME;
              start_d = pos_q;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    q_push_o = a_v || b_v;
    q_data_o.two = a_v && b_v;
    q_data_o.r0 = a_v ? rec_a : rec_b;
    q_data_o.r1 = rec_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q <= '0;
      start_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pos_q <= pos_d;
      start_q <= start_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

@@ sv/slx_fifo.sv @@
// Short register queue of token events between the lexer and the grammar stage.
// Depends on slx_pkg for the entry type and depth.
module slx_fifo import slx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  slx_entry_t data_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output slx_entry_t data_o
);

  slx_entry_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

endmodule

@@ sv/slx_back.sv @@
// Grammar back end: runs the syntax state machine, counts tokens, drives results.
// Depends on slx_pkg; reads entries from slx_fifo, one record per cycle while the output is not stalled.
module slx_back import slx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  slx_entry_t        q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [2:0]        token_kind_o,
  output logic [StartW-1:0] start_offset_o,
  output logic [LenW-1:0]   token_length_o,
  output logic [CountW-1:0] token_count_o,
  output logic              line_ok_o,
  output logic              overflow_o,
  output logic              last_o
);

  gram_state_e       gs_q, gs_d;
  logic [CountW-1:0] tokens_q, tokens_d;
  logic              sub_q, sub_d;
  logic              valid_q, valid_d;
  logic              load, is_final, ok;
  slx_rec_t          rec;

  assign rec = sub_q ? q_data_i.r1 : q_data_i.r0;
  assign is_final = !q_data_i.two || sub_q;
  assign load = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = load && is_final;
  assign out_valid_o = valid_q;
  assign ok = !rec.ovf && ((gs_q == GS_START) || (gs_q == GS_NAME) || (gs_q == GS_AMP));

  always_comb begin
    gs_d = gs_q;
    tokens_d = tokens_q;
    sub_d = sub_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      sub_d = !is_final;
      if (rec.is_verdict) begin
        gs_d = GS_START;
        tokens_d = '0;
      end else begin
        tokens_d = tokens_q + CountW'(1);
        if (rec.tk == TK_NAME) begin
          gs_d = (gs_q == GS_ERR) ? GS_ERR : GS_NAME;
        end else if (gs_q != GS_NAME) begin
          gs_d = GS_ERR;
        end else begin
          case (rec.tk)
            TK_IN, TK_OUT, TK_APPEND: gs_d = GS_REDIR;
            TK_PIPE: gs_d = GS_PIPE;
            TK_SEMI: gs_d = GS_SEMI;
            default: gs_d = GS_AMP;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= GS_START;
      tokens_q <= '0;
      sub_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      gs_q <= gs_d;
      tokens_q <= tokens_d;
      sub_q <= sub_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o <= rec.is_verdict;
      token_kind_o <= rec.tk;
      start_offset_o <= rec.start;
      token_length_o <= rec.len;
      token_count_o <= rec.is_verdict ? tokens_q : '0;
      line_ok_o <= rec.is_verdict && ok;
      overflow_o <= rec.is_verdict && rec.ovf;
      last_o <= is_final;
    end
  end

endmodule

@@ sv/shell_line_lexer_validator_unit.sv @@
// Top level of the shell line lexer and validator: lexer, event queue, grammar stage.
// Depends on slx_pkg, slx_front, slx_fifo and slx_back.
//
//   Channel | Direction | Handshake                 | Payload
//   input   | in        | in_valid_i / in_stall_o   | ch_i
//   output  | out       | out_valid_o / out_stall_i | kind_o .. last_o
//
// One byte is taken per cycle while the queue has room; a byte that causes two records holds the grammar
// stage while both records are read out, and the four-entry queue absorbs these bursts.
// Each record passes through the queue and then the registered outputs of the grammar stage.
// Reset is asynchronous and active low; no clearing pass follows it.
// A stalled output holds its record while the queue keeps filling.
module shell_line_lexer_validator_unit import slx_pkg::*; #(
  parameter int MAX_LINE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [2:0]  token_kind_o,
  output logic [11:0] start_offset_o,
  output logic [12:0] token_length_o,
  output logic [12:0] token_count_o,
  output logic        line_ok_o,
  output logic        overflow_o,
  output logic        last_o
);

  logic       push, full, q_valid, pop;
  slx_entry_t push_data, q_data;

  slx_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  slx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_data)
  );

  slx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .token_count_o  (token_count_o),
    .line_ok_o      (line_ok_o),
    .overflow_o     (overflow_o),
    .last_o         (last_o)
  );

endmodule

@@ sv/slx_checker.sv @@
// Port-level checks of the shell line lexer and validator, with the bind to the top.
// Depends only on the ports of shell_line_lexer_validator_unit.
module slx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  ch_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [2:0]  token_kind_o,
  input logic [11:0] start_offset_o,
  input logic [12:0] token_length_o,
  input logic [12:0] token_count_o,
  input logic        line_ok_o,
  input logic        overflow_o,
  input logic        last_o
);

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("verdict transaction is not marked last");

  a_overflow_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && overflow_o |-> !line_ok_o)
    else $error("overflowed line reported as valid");

  a_token_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> token_count_o == 13'd0 && !line_ok_o && !overflow_o)
    else $error("token transaction carries verdict fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(token_length_o) && $stable(last_o))
    else $error("stalled output transaction changed");

endmodule

bind shell_line_lexer_validator_unit slx_checker u_slx_checker (.*);

@@ dv/tb.sv @@
// Self-checking testbench for shell_line_lexer_validator_unit: streams command-line bytes in,
// predicts every token and end-of-line verdict, and checks each output transaction in order.
// Depends on slx_pkg for port-level types and character constants.
`timescale 1ns / 100ps

module tb;
  import slx_pkg::*;

  localparam int MaxLine = 4096;
  localparam int RandomItems = 1050;
  localparam int CalmItems = 150;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic        kind;
    tok_kind_e   tk;
    logic [11:0] start;
    logic [12:0] len;
    logic [12:0] cnt;
    logic        ok;
    logic        ovf;
    logic        last;
  } lex_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       hold;
  } feed_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [2:0]  token_kind_o;
  logic [11:0] start_offset_o;
  logic [12:0] token_length_o;
  logic [12:0] token_count_o;
  logic        line_ok_o;
  logic        overflow_o;
  logic        last_o;

  shell_line_lexer_validator_unit #(
    .MAX_LINE(MaxLine)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .token_kind_o  (token_kind_o),
    .start_offset_o(start_offset_o),
    .token_length_o(token_length_o),
    .token_count_o (token_count_o),
    .line_ok_o     (line_ok_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

  feed_item_t  feed_q[$];
  lex_result_t expected_q[$];
  int          fail_cnt = 0;
  int          cycles = 0;
  int          idle_left = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;
  bit          hold_next = 1'b0;

  lex_mode_e   lx_mode = MODE_IDLE;
  gram_state_e lx_gram = GS_START;
  int unsigned lx_pos = 0;
  int unsigned lx_tstart = 0;
  int unsigned lx_count = 0;
  logic        lx_ovf = 1'b0;
  lex_result_t held_rec;
  bit          held_ok = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit is_blank(logic [7:0] c);
    return c inside {ChSpace, ChTab, ChNewline, ChVtab, ChFeed, ChReturn};
  endfunction

  function automatic bit is_op(logic [7:0] c);
    return c inside {ChPipe, ChAmp, ChSemi, ChLess, ChGreater};
  endfunction

  function automatic void stage_result(lex_result_t r);
    if (held_ok) expected_q.push_back(held_rec);
    held_rec = r;
    held_ok = 1'b1;
  endfunction

  function automatic void flush_results();
    if (held_ok) begin
      held_rec.last = 1'b1;
      expected_q.push_back(held_rec);
      held_ok = 1'b0;
    end
  endfunction

  function automatic void feed_grammar(tok_kind_e tk);
    if (tk == TK_NAME) begin
      if (lx_gram != GS_ERR) lx_gram = GS_NAME;
    end else if (lx_gram != GS_NAME) begin
      lx_gram = GS_ERR;
    end else begin
      case (tk)
        TK_IN, TK_OUT, TK_APPEND: lx_gram = GS_REDIR;
        TK_PIPE: lx_gram = GS_PIPE;
        TK_SEMI: lx_gram = GS_SEMI;
        default: lx_gram = GS_AMP;
      endcase
    end
  endfunction

  function automatic void emit_token(tok_kind_e tk, int unsigned start, int unsigned len);
    lex_result_t r;
    r = '0;
    r.tk = tk;
    r.start = start[11:0];
    r.len = len[12:0];
    stage_result(r);
    feed_grammar(tk);
    lx_count++;
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    int unsigned p;
    lex_result_t v;
    bit appended;
    appended = 1'b0;
    if (c == ChNul) begin
      if (lx_mode == MODE_NAME) emit_token(TK_NAME, lx_tstart, lx_pos - lx_tstart);
      else if (lx_mode == MODE_GT) emit_token(TK_OUT, lx_tstart, 1);
      v = '0;
      v.kind = 1'b1;
      v.cnt = lx_count[12:0];
      v.ok = (lx_gram inside {GS_START, GS_NAME, GS_AMP}) && !lx_ovf;
      v.ovf = lx_ovf;
      stage_result(v);
      flush_results();
      lx_mode = MODE_IDLE;
      lx_gram = GS_START;
      lx_pos = 0;
      lx_tstart = 0;
      lx_count = 0;
      lx_ovf = 1'b0;
    end else if (lx_pos >= MaxLine) begin
      lx_ovf = 1'b1;
    end else begin
      p = lx_pos;
      lx_pos++;
      if (lx_mode == MODE_GT) begin
        lx_mode = MODE_IDLE;
        if (c == ChGreater) begin
          emit_token(TK_APPEND, lx_tstart, 2);
          appended = 1'b1;
        end else begin
          emit_token(TK_OUT, lx_tstart, 1);
        end
      end else if (lx_mode == MODE_NAME && (is_blank(c) || is_op(c))) begin
        lx_mode = MODE_IDLE;
        emit_token(TK_NAME, lx_tstart, p - lx_tstart);
      end
      if (!appended && lx_mode == MODE_IDLE) begin
        if (is_blank(c)) begin
        end else if (c == ChPipe) begin
          emit_token(TK_PIPE, p, 1);
        end else if (c == ChAmp) begin
          emit_token(TK_AMP, p, 1);
        end else if (c == ChSemi) begin
          emit_token(TK_SEMI, p, 1);
        end else if (c == ChLess) begin
          emit_token(TK_IN, p, 1);
        end else if (c == ChGreater) begin
          lx_mode = MODE_GT;
          lx_tstart = p;
        end else begin
          lx_mode = MODE_NAME;
          lx_tstart = p;
        end
      end
      flush_results();
    end
  endfunction

  function automatic string fmt_result(lex_result_t r);
    return $sformatf("kind=%0d tk=%0d start=%0d len=%0d count=%0d ok=%0d ovf=%0d last=%0d",
                     r.kind, r.tk, r.start, r.len, r.cnt, r.ok, r.ovf, r.last);
  endfunction

  function automatic void check_result();
    lex_result_t got;
    lex_result_t want;
    got.kind = kind_o;
    got.tk = tok_kind_e'(token_kind_o);
    got.start = start_offset_o;
    got.len = token_length_o;
    got.cnt = token_count_o;
    got.ok = line_ok_o;
    got.ovf = overflow_o;
    got.last = last_o;
    if (expected_q.size() == 0) begin
      if (fail_cnt < 10) $display("Unexpected result: %s", fmt_result(got));
      fail_cnt++;
    end else begin
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.tk !== want.tk || got.start !== want.start ||
          got.len !== want.len || got.cnt !== want.cnt || got.ok !== want.ok ||
          got.ovf !== want.ovf || got.last !== want.last) begin
        if (fail_cnt < 10) begin
          $display("Mismatch: expected %s", fmt_result(want));
          $display("          actual   %s", fmt_result(got));
        end
        fail_cnt++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i <= '0;
      idle_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_byte(ch_i);
      if (!in_valid_i || !in_stall_o) begin
        calm = feed_q.size() < CalmItems;
        if (idle_left != 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (feed_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (feed_q[0].hold && expected_q.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          idle_left = $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          ch_i <= feed_q[0].ch;
          void'(feed_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void put_byte(logic [7:0] c);
    feed_item_t it;
    it.ch = c;
    it.hold = hold_next;
    hold_next = 1'b0;
    feed_q.push_back(it);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_blank(c) || is_op(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0: return ChSpace;
      1: return ChTab;
      2: return ChNewline;
      3: return ChVtab;
      4: return ChFeed;
      default: return ChReturn;
    endcase
  endfunction

  function automatic logic [7:0] op_byte();
    case ($urandom_range(0, 4))
      0: return ChPipe;
      1: return ChAmp;
      2: return ChSemi;
      3: return ChLess;
      default: return ChGreater;
    endcase
  endfunction

  function automatic void put_gap(int lo);
    repeat ($urandom_range(lo, 2)) put_byte(blank_byte());
  endfunction

  function automatic void put_name();
    repeat ($urandom_range(1, 5)) put_byte(name_byte());
  endfunction

  function automatic void put_atomic();
    put_name();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) == 0) begin
        put_gap(1);
      end else begin
        put_gap(0);
        case ($urandom_range(0, 2))
          0: put_byte(ChLess);
          1: put_byte(ChGreater);
          default: begin
            put_byte(ChGreater);
            put_byte(ChGreater);
          end
        endcase
        put_gap(0);
      end
      put_name();
    end
  endfunction

  function automatic void put_group();
    put_atomic();
    repeat ($urandom_range(0, 2)) begin
      put_gap(0);
      put_byte(ChPipe);
      put_gap(0);
      put_atomic();
    end
  endfunction

  function automatic void put_valid_line();
    put_gap(0);
    put_group();
    repeat ($urandom_range(0, 2)) begin
      put_gap(0);
      put_byte($urandom_range(0, 1) ? ChSemi : ChAmp);
      put_gap(0);
      put_group();
    end
    if ($urandom_range(0, 2) == 0) put_byte(ChAmp);
    put_gap(0);
    put_byte(ChNul);
  endfunction

  function automatic void put_soup_line();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0: put_name();
        1: put_byte(op_byte());
        2: put_byte(blank_byte());
        default: put_byte(8'($urandom_range(1, 255)));
      endcase
    end
    put_byte(ChNul);
  endfunction

  initial begin
    int start_size;
    int rand_items;
    rand_items = 0;

    put_byte(ChNul);
    put_text("a>>b<c|d>e;f&");
    put_byte(ChNul);
    put_text("x;");
    put_byte(ChNul);
    put_text("a>|b");
    put_byte(ChNul);
    put_byte(ChTab);
    put_byte(ChNewline);
    put_byte(ChVtab);
    put_byte(ChFeed);
    put_byte(ChReturn);
    put_byte(ChSpace);
    put_text("q>");
    put_byte(ChNul);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(8'h01);
    put_byte(8'h7F);
    put_byte(ChNul);

    hold_next = 1'b1;
    while (rand_items < RandomItems) begin
      start_size = feed_q.size();
      if ($urandom_range(0, 14) == 0) hold_next = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2: put_soup_line();
        3: begin
          repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
          put_byte(ChNul);
        end
        default: put_valid_line();
      endcase
      rand_items += feed_q.size() - start_size;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (feed_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/slx_pkg.sv
sv/slx_front.sv
sv/slx_fifo.sv
sv/slx_back.sv
sv/shell_line_lexer_validator_unit.sv
sv/slx_checker.sv
dv/tb.sv
